// File: hw/rtl/bvci_pkg.sv
// Shared types, constants and the voltage/charge ROM of the charge interpolator.
`timescale 1ns / 1ps

package bvci_pkg;

  localparam int VOLT_W   = 16;  // input sample width, 0.01 V units
  localparam int CHG_W    = 14;  // result width, 0.01 % units
  localparam int ROM_ROWS = 64;
  localparam int ROW_W    = 6;   // index into the ROM
  localparam int TV_W     = 12;  // width of a table voltage
  localparam int TC_W     = 10;  // width of a table charge, 0.1 % units
  localparam int DEN_W    = TV_W;
  localparam int PROD_W   = TV_W + CHG_W;
  localparam int QUOT_W   = CHG_W;
  localparam int DIV_BITS = 2;   // quotient bits resolved per divider stage

  localparam logic [CHG_W-1:0] FULL_CHARGE = 14'd10000;
  localparam logic [ROW_W-1:0] TOP_ROW     = 6'd0;

  typedef struct packed {
    logic [CHG_W-1:0] base;     // lower point charge scaled to 0.01 %
    logic             sat_hi;   // sample at or above the top point
    logic             sat_lo;   // sample at or below the bottom point
    logic             in_span;
    logic             dv_zero;  // degenerate segment of zero width
  } side_t;

  typedef struct packed {
    logic [TV_W-1:0]  off;      // sample minus lower segment voltage
    logic [TV_W-1:0]  dv;       // segment voltage width
    logic [CHG_W-1:0] dp10;     // segment charge rise in 0.01 % units
    side_t            side;
  } seg_t;

  typedef struct packed {
    logic [PROD_W-1:0] num;
    logic [DEN_W-1:0]  den;
    side_t             side;
  } div_req_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    side_t             side;
  } div_rsp_t;

  // Table voltages in descending order; rows past the given points read as zero.
  function automatic logic [TV_W-1:0] rom_volt(input logic [ROW_W-1:0] row);
    logic [TV_W-1:0] v;
    case (row)
      6'd0:    v = 12'd2940;
      6'd1:    v = 12'd2841;
      6'd2:    v = 12'd2833;
      6'd3:    v = 12'd2823;
      6'd4:    v = 12'd2805;
      6'd5:    v = 12'd2784;
      6'd6:    v = 12'd2761;
      6'd7:    v = 12'd2739;
      6'd8:    v = 12'd2719;
      6'd9:    v = 12'd2700;
      6'd10:   v = 12'd2682;
      6'd11:   v = 12'd2664;
      6'd12:   v = 12'd2645;
      6'd13:   v = 12'd2626;
      6'd14:   v = 12'd2610;
      6'd15:   v = 12'd2583;
      6'd16:   v = 12'd2565;
      6'd17:   v = 12'd2549;
      6'd18:   v = 12'd2534;
      6'd19:   v = 12'd2521;
      6'd20:   v = 12'd2507;
      6'd21:   v = 12'd2493;
      6'd22:   v = 12'd2477;
      6'd23:   v = 12'd2458;
      6'd24:   v = 12'd2437;
      6'd25:   v = 12'd2420;
      6'd26:   v = 12'd2404;
      6'd27:   v = 12'd2372;
      6'd28:   v = 12'd2329;
      6'd29:   v = 12'd2272;
      6'd30:   v = 12'd2200;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Table charges in 0.1 % units, matching rom_volt row for row.
  function automatic logic [TC_W-1:0] rom_charge(input logic [ROW_W-1:0] row);
    logic [TC_W-1:0] c;
    case (row)
      6'd0:    c = 10'd1000;
      6'd1:    c = 10'd908;
      6'd2:    c = 10'd877;
      6'd3:    c = 10'd846;
      6'd4:    c = 10'd815;
      6'd5:    c = 10'd784;
      6'd6:    c = 10'd753;
      6'd7:    c = 10'd722;
      6'd8:    c = 10'd691;
      6'd9:    c = 10'd660;
      6'd10:   c = 10'd629;
      6'd11:   c = 10'd598;
      6'd12:   c = 10'd567;
      6'd13:   c = 10'd536;
      6'd14:   c = 10'd505;
      6'd15:   c = 10'd474;
      6'd16:   c = 10'd443;
      6'd17:   c = 10'd412;
      6'd18:   c = 10'd381;
      6'd19:   c = 10'd350;
      6'd20:   c = 10'd319;
      6'd21:   c = 10'd288;
      6'd22:   c = 10'd257;
      6'd23:   c = 10'd226;
      6'd24:   c = 10'd195;
      6'd25:   c = 10'd164;
      6'd26:   c = 10'd133;
      6'd27:   c = 10'd102;
      6'd28:   c = 10'd71;
      6'd29:   c = 10'd40;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/bvci_in_if.sv
// Request channel carrying one voltage sample.
`timescale 1ns / 1ps

interface bvci_in_if import bvci_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] voltage_centivolts;

  modport source (output valid, output voltage_centivolts, input ready);
  modport sink   (input valid, input voltage_centivolts, output ready);
endinterface

// File: hw/rtl/bvci_out_if.sv
// Result channel carrying the state of charge and the span flag.
`timescale 1ns / 1ps

interface bvci_out_if import bvci_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CHG_W-1:0] charge_centipercent;
  logic             voltage_in_span;

  modport source (output valid, output charge_centipercent, output voltage_in_span, input ready);
  modport sink   (input valid, input charge_centipercent, input voltage_in_span, output ready);
endinterface

// File: hw/rtl/battery_voltage_to_charge_interp_top.sv
// Top level of the battery voltage to state-of-charge interpolator.
`timescale 1ns / 1ps

// Usage:
// A voltage sample (0.01 V units) is offered on in_ch; each request yields
// one result on out_ch: the state of charge in 0.01 % units, rounded down,
// by linear interpolation between points of a constant ROM table, and a
// flag that says whether the sample lies within the table's voltage span.
// Samples at or above the top point give 10000, at or below the bottom 0.
// From acceptance to out_ch.valid a request passes two stages for the
// segment search and ROM fetch, one for the multiply, seven for the divider
// (two quotient bits each) and one output register.
// One request per cycle unless out_ch stalls, set by the fully pipelined divider.
// Every stage has its own valid bit and loads whenever the stage after it
// is empty or moving, so a stall on out_ch holds the results in place and
// lets empty stages fill; in_ch.ready falls only once every stage is full.
// Synchronous reset clears all valid bits; the data registers are not reset.
module battery_voltage_to_charge_interp_top import bvci_pkg::*; #(
  parameter int TABLE_POINTS = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  bvci_in_if.sink    in_ch,
  bvci_out_if.source out_ch
);

  logic             seg_valid, seg_ready;
  seg_t             seg_data;
  logic             mul_vld_r, mul_en;
  div_req_t         mul_req_r, mul_req_nxt;
  logic             div_in_ready, div_valid, out_en;
  div_rsp_t         div_rsp;
  logic             out_vld_r;
  logic [CHG_W-1:0] out_chg_r, out_chg_nxt;
  logic             out_span_r;

  bvci_seg #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_volt   (in_ch.voltage_centivolts),
    .out_valid (seg_valid),
    .out_ready (seg_ready),
    .out_seg   (seg_data)
  );

  // Multiply stage: the offset into the segment times the charge rise.
  assign mul_en    = !mul_vld_r || div_in_ready;
  assign seg_ready = mul_en;

  always_comb begin
    mul_req_nxt.num  = PROD_W'(seg_data.off) * PROD_W'(seg_data.dp10);
    mul_req_nxt.den  = seg_data.dv;
    mul_req_nxt.side = seg_data.side;
  end

  bvci_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_vld_r),
    .in_ready  (div_in_ready),
    .in_req    (mul_req_r),
    .out_valid (div_valid),
    .out_ready (out_en),
    .out_rsp   (div_rsp)
  );

  // Output stage: the lower point's charge plus the interpolated rise,
  // overridden by the saturation cases; a zero-width segment gives the base.
  assign out_en = !out_vld_r || out_ch.ready;

  always_comb begin
    logic [CHG_W:0] sum;
    sum = {1'b0, div_rsp.side.base} + {1'b0, div_rsp.quot};
    if (div_rsp.side.sat_hi) begin
      out_chg_nxt = FULL_CHARGE;
    end else if (div_rsp.side.sat_lo) begin
      out_chg_nxt = '0;
    end else if (div_rsp.side.dv_zero) begin
      out_chg_nxt = div_rsp.side.base;
    end else if (sum > {1'b0, FULL_CHARGE}) begin
      out_chg_nxt = FULL_CHARGE;
    end else begin
      out_chg_nxt = sum[CHG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (mul_en) mul_vld_r <= seg_valid;
      if (out_en) out_vld_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) mul_req_r <= mul_req_nxt;
    if (out_en) begin
      out_chg_r  <= out_chg_nxt;
      out_span_r <= div_rsp.side.in_span;
    end
  end

  assign out_ch.valid               = out_vld_r;
  assign out_ch.charge_centipercent = out_chg_r;
  assign out_ch.voltage_in_span     = out_span_r;

  a_charge_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.charge_centipercent <= FULL_CHARGE)
    else $error("charge above full scale");

  a_out_of_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.voltage_in_span |->
      (out_ch.charge_centipercent == '0 || out_ch.charge_centipercent == FULL_CHARGE))
    else $error("sample outside the table span did not saturate");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !mul_vld_r)
    else $error("pipeline not empty after reset");

  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r && !div_in_ready |=> mul_vld_r && $stable(mul_req_r))
    else $error("multiply stage lost a request while the divider stalled");

endmodule

// File: hw/rtl/bvci_seg.sv
// Segment search and ROM fetch: two pipeline stages.
`timescale 1ns / 1ps

module bvci_seg import bvci_pkg::*; #(
  parameter int TABLE_POINTS = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VOLT_W-1:0] in_volt,
  output logic              out_valid,
  input  logic              out_ready,
  output seg_t              out_seg
);

  localparam logic [ROW_W-1:0] BOT_ROW = ROW_W'(TABLE_POINTS - 1);

  logic              s1_vld_r;
  logic [VOLT_W-1:0] s1_volt_r;
  logic [ROW_W-1:0]  s1_row_r, s1_row_nxt;
  logic              s1_hi_r, s1_lo_r, s1_span_r;
  logic              s1_hi_nxt, s1_lo_nxt, s1_span_nxt;
  logic              s2_vld_r;
  seg_t              s2_seg_r, s2_seg_nxt;
  logic              s1_en, s2_en;

  assign s2_en    = !s2_vld_r || out_ready;
  assign s1_en    = !s1_vld_r || s2_en;
  assign in_ready = s1_en;

  // Stage 1: the first segment from the top whose lower point lies at or
  // below the sample. Scanning rows downward leaves the topmost hit.
  always_comb begin
    logic [TV_W-1:0] v_top, v_bot;
    v_top      = rom_volt(TOP_ROW);
    v_bot      = rom_volt(BOT_ROW);
    s1_row_nxt = '0;
    for (int r = ROM_ROWS - 1; r >= 1; r--) begin
      if (r <= TABLE_POINTS - 1 && in_volt >= VOLT_W'(rom_volt(ROW_W'(r)))) begin
        s1_row_nxt = ROW_W'(r - 1);
      end
    end
    s1_hi_nxt   = in_volt >= VOLT_W'(v_top);
    s1_lo_nxt   = in_volt <= VOLT_W'(v_bot);
    s1_span_nxt = (in_volt >= VOLT_W'(v_bot)) && (in_volt <= VOLT_W'(v_top));
  end

  // Stage 2: fetch both segment ends and form the differences.
  always_comb begin
    logic [ROW_W-1:0] lo_row;
    logic [TV_W-1:0]  vh, vl;
    logic [TC_W-1:0]  ph, pl, dp;
    lo_row = s1_row_r + ROW_W'(1);
    vh     = rom_volt(s1_row_r);
    vl     = rom_volt(lo_row);
    ph     = rom_charge(s1_row_r);
    pl     = rom_charge(lo_row);
    dp     = (ph >= pl) ? (ph - pl) : '0;
    s2_seg_nxt.off          = TV_W'(s1_volt_r - VOLT_W'(vl));
    s2_seg_nxt.dv           = vh - vl;
    s2_seg_nxt.dp10         = CHG_W'(dp) * CHG_W'(10);
    s2_seg_nxt.side.base    = CHG_W'(pl) * CHG_W'(10);
    s2_seg_nxt.side.sat_hi  = s1_hi_r;
    s2_seg_nxt.side.sat_lo  = s1_lo_r;
    s2_seg_nxt.side.in_span = s1_span_r;
    s2_seg_nxt.side.dv_zero = (vh == vl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_en) s1_vld_r <= in_valid;
      if (s2_en) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_volt_r <= in_volt;
      s1_row_r  <= s1_row_nxt;
      s1_hi_r   <= s1_hi_nxt;
      s1_lo_r   <= s1_lo_nxt;
      s1_span_r <= s1_span_nxt;
    end
    if (s2_en) s2_seg_r <= s2_seg_nxt;
  end

  assign out_valid = s2_vld_r;
  assign out_seg   = s2_seg_r;

endmodule

// File: hw/rtl/bvci_div.sv
// Pipelined restoring divider, a fixed number of quotient bits per stage.
`timescale 1ns / 1ps

module bvci_div import bvci_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  div_req_t in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output div_rsp_t out_rsp
);

  localparam int NS = QUOT_W / DIV_BITS;

  logic [NS-1:0]     vld_r, en, src_vld;
  logic [DEN_W-1:0]  rem_r [NS];
  logic [DEN_W-1:0]  rem_nxt [NS];
  logic [DEN_W-1:0]  src_rem [NS];
  logic [QUOT_W-1:0] low_r [NS];
  logic [QUOT_W-1:0] low_nxt [NS];
  logic [QUOT_W-1:0] src_low [NS];
  logic [QUOT_W-1:0] q_r [NS];
  logic [QUOT_W-1:0] q_nxt [NS];
  logic [QUOT_W-1:0] src_q [NS];
  logic [DEN_W-1:0]  den_r [NS];
  logic [DEN_W-1:0]  src_den [NS];
  side_t             side_r [NS];
  side_t             src_side [NS];

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  // The high part of the numerator is already below the divisor, so only the
  // low quotient bits remain to be resolved.
  always_comb begin
    src_vld     = {vld_r[NS-2:0], in_valid};
    src_rem[0]  = in_req.num[PROD_W-1:QUOT_W];
    src_low[0]  = in_req.num[QUOT_W-1:0];
    src_q[0]    = '0;
    src_den[0]  = in_req.den;
    src_side[0] = in_req.side;
    for (int k = 1; k < NS; k++) begin
      src_rem[k]  = rem_r[k-1];
      src_low[k]  = low_r[k-1];
      src_q[k]    = q_r[k-1];
      src_den[k]  = den_r[k-1];
      src_side[k] = side_r[k-1];
    end
  end

  always_comb begin
    logic [DEN_W:0]    tr;
    logic [DEN_W-1:0]  rem_v;
    logic [QUOT_W-1:0] low_v, q_v;
    for (int k = 0; k < NS; k++) begin
      rem_v = src_rem[k];
      low_v = src_low[k];
      q_v   = src_q[k];
      for (int b = 0; b < DIV_BITS; b++) begin
        tr    = {rem_v, low_v[QUOT_W-1]};
        low_v = {low_v[QUOT_W-2:0], 1'b0};
        if (tr >= {1'b0, src_den[k]}) begin
          rem_v = DEN_W'(tr - {1'b0, src_den[k]});
          q_v   = {q_v[QUOT_W-2:0], 1'b1};
        end else begin
          rem_v = tr[DEN_W-1:0];
          q_v   = {q_v[QUOT_W-2:0], 1'b0};
        end
      end
      rem_nxt[k] = rem_v;
      low_nxt[k] = low_v;
      q_nxt[k]   = q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) vld_r[k] <= src_vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt[k];
        low_r[k]  <= low_nxt[k];
        q_r[k]    <= q_nxt[k];
        den_r[k]  <= src_den[k];
        side_r[k] <= src_side[k];
      end
    end
  end

  assign out_valid    = vld_r[NS-1];
  assign out_rsp.quot = q_r[NS-1];
  assign out_rsp.side = side_r[NS-1];

endmodule
